// ===== hw/rtl/ssnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_pkg
// shared types, codes and font tables for the seven-segment number formatter
// ----------------------------------------------------------------------------
package ssnf_pkg;

   localparam int NUM_DIGITS  = 8;
   localparam int HALF_DIGITS = 4;
   localparam int DIGIT_AW    = $clog2(NUM_DIGITS);
   localparam int SEG_W       = 8;
   localparam int MAG_BITS    = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int STEP_W      = $clog2(MAG_BITS);

   localparam logic [SEG_W-1:0] DASH_CODE  = 8'h40;
   localparam logic [SEG_W-1:0] BLANK_CODE = 8'h00;

   typedef enum logic [2:0] {
      CMD_PRINT_LEFT  = 3'd0,
      CMD_PRINT_RIGHT = 3'd1,
      CMD_PRINT_ALL   = 3'd2,
      CMD_RAW         = 3'd3,
      CMD_CLEAR       = 3'd4,
      CMD_FRAME       = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_MEASURE,
      ST_PLACE,
      ST_F_ADDR,
      ST_F_READ,
      ST_F_SEG,
      ST_F_ZERO
   } state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic signed [31:0] number;
      logic              left_justify;
      logic [2:0]        digit_index;
      logic [7:0]        segment_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                        done;
      logic                        neg;
      logic [BCD_DIGITS-1:0][3:0]  digits;
   } bcd_status_type;

   function automatic logic [SEG_W-1:0] ssnf_font(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7D;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h6F;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

   // board wiring: pair n of the frame carries this logical digit
   function automatic logic [DIGIT_AW-1:0] ssnf_board(input logic [DIGIT_AW-1:0] pair);
      logic [DIGIT_AW-1:0] digit;
      unique case (pair)
         3'd0:    digit = 3'd4;
         3'd1:    digit = 3'd5;
         3'd2:    digit = 3'd6;
         3'd3:    digit = 3'd7;
         3'd4:    digit = 3'd0;
         3'd5:    digit = 3'd1;
         3'd6:    digit = 3'd2;
         default: digit = 3'd3;
      endcase
      return digit;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/seven_segment_number_formatter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_core
// eight-digit segment buffer with decimal print, raw write, clear and frame out
// ----------------------------------------------------------------------------
// raw write and clear: taken while idle, back to back
// half and eight-digit print: acceptance, one converter step per magnitude bit, the
//   converter done flag, a measure state, then one ram write per digit of the area
// frame: 17 transfers, no new item taken before the closing byte is loaded,
//   one ram read per digit pair
// reset clears the digit valid flags at once; the buffer reads as blank
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_core
   import ssnf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_payload
);

   // fsm and item context
   state_type           state_ff, state_in;
   logic [2:0]          cmd_ff;
   logic                left_ff;
   logic [DIGIT_AW-1:0] pos_ff;
   logic [DIGIT_AW-1:0] pair_ff;
   logic [3:0]          nd_ff;
   logic [3:0]          len_ff;
   logic                ovf_ff;
   logic                seg_valid_ff;

   // per-digit written flags, cleared by reset and by the clear command
   logic [NUM_DIGITS-1:0] valid_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff;

   // control from the output decode
   logic                accept;
   logic                out_free;
   logic                bcd_start;
   logic signed [31:0]  bcd_value;
   logic                ram_we;
   logic [DIGIT_AW-1:0] ram_waddr;
   logic [SEG_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [DIGIT_AW-1:0] ram_raddr;
   logic [SEG_W-1:0]    ram_rdata;
   logic                clear_all;
   logic                latch_item;
   logic                measure;
   logic                pos_step;
   logic                pair_start;
   logic                pair_step;
   logic                load_rsp;
   logic [SEG_W-1:0]    load_byte;
   logic                load_last;
   logic                is_print;
   logic                place_done;

   bcd_status_type bcd_res;

   // placement arithmetic
   logic [3:0]          area_size;
   logic [DIGIT_AW-1:0] area_base;
   logic [3:0]          start_pos;
   logic [3:0]          pos_x;
   logic [3:0]          rel;
   logic [3:0]          dsel;
   logic                in_text;
   logic [3:0]          sel_digit;
   logic [SEG_W-1:0]    place_code;
   logic [3:0]          nd_calc;
   logic [3:0]          len_calc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_print  = (req_payload.cmd == CMD_PRINT_LEFT) ||
                      (req_payload.cmd == CMD_PRINT_RIGHT) ||
                      (req_payload.cmd == CMD_PRINT_ALL);

   // half prints take the low 16 bits as a signed value
   assign bcd_value = (req_payload.cmd == CMD_PRINT_ALL) ? req_payload.number :
                      {{16{req_payload.number[15]}}, req_payload.number[15:0]};

   ssnf_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (bcd_value),
      .status (bcd_res)
   );

   ssnf_ram #(
      .WIDTH (SEG_W),
      .DEPTH (NUM_DIGITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // significant digit count of the converted magnitude, at least one
   always_comb begin
      nd_calc = 4'd1;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_res.digits[d] != 4'd0) begin
            nd_calc = 4'(d + 1);
         end
      end
      len_calc = nd_calc + {3'd0, bcd_res.neg};
   end

   // code for one position of the target area
   always_comb begin
      area_size = (cmd_ff == CMD_PRINT_ALL) ? 4'(NUM_DIGITS) : 4'(HALF_DIGITS);
      area_base = (cmd_ff == CMD_PRINT_RIGHT) ? DIGIT_AW'(HALF_DIGITS) : '0;
      start_pos = left_ff ? 4'd0 : area_size - len_ff;
      pos_x     = {1'b0, pos_ff};
      rel       = pos_x - start_pos;
      in_text   = (pos_x >= start_pos) && (pos_x < start_pos + len_ff);
      // index from the least significant digit
      dsel      = nd_ff - 4'd1 - rel + {3'd0, bcd_res.neg};
      sel_digit = 4'd0;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (dsel == 4'(d)) begin
            sel_digit = bcd_res.digits[d];
         end
      end
      if (ovf_ff && cmd_ff != CMD_PRINT_ALL) begin
         // half overflow: dash, blank, blank, dash
         place_code = (pos_ff == '0 || pos_ff == DIGIT_AW'(HALF_DIGITS - 1)) ?
                      DASH_CODE : BLANK_CODE;
      end else if (ovf_ff) begin
         // eight-digit overflow: 9999 fills each half
         place_code = ssnf_font(4'd9);
      end else if (!in_text) begin
         place_code = BLANK_CODE;
      end else if (bcd_res.neg && rel == 4'd0) begin
         place_code = DASH_CODE;
      end else begin
         place_code = ssnf_font(sel_digit);
      end
      place_done = ({1'b0, pos_ff} == area_size - 4'd1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_print) begin
               state_in = ST_CONV;
            end else if (accept && req_payload.cmd == CMD_FRAME) begin
               state_in = ST_F_ADDR;
            end
         end
         ST_CONV: begin
            if (bcd_res.done) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: state_in = ST_PLACE;
         ST_PLACE: begin
            if (place_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_F_ADDR: begin
            if (out_free) begin
               state_in = ST_F_READ;
            end
         end
         ST_F_READ: state_in = ST_F_SEG;
         ST_F_SEG: begin
            if (out_free) begin
               state_in = ST_F_ZERO;
            end
         end
         ST_F_ZERO: begin
            if (out_free) begin
               state_in = (pair_ff == DIGIT_AW'(NUM_DIGITS - 1)) ? ST_IDLE : ST_F_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the fsm
   always_comb begin
      bcd_start  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = area_base + pos_ff;
      ram_wdata  = place_code;
      ram_re     = 1'b0;
      ram_raddr  = ssnf_board(pair_ff);
      clear_all  = 1'b0;
      latch_item = 1'b0;
      measure    = 1'b0;
      pos_step   = 1'b0;
      pair_start = 1'b0;
      pair_step  = 1'b0;
      load_rsp   = 1'b0;
      load_byte  = BLANK_CODE;
      load_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               latch_item = 1'b1;
               bcd_start  = is_print;
               if (req_payload.cmd == CMD_RAW) begin
                  ram_we    = 1'b1;
                  ram_waddr = req_payload.digit_index;
                  ram_wdata = req_payload.segment_bits;
               end
               clear_all = (req_payload.cmd == CMD_CLEAR);
            end
         end
         ST_CONV:    ;
         ST_MEASURE: measure = 1'b1;
         ST_PLACE: begin
            ram_we   = 1'b1;
            pos_step = 1'b1;
         end
         ST_F_ADDR: begin
            // address byte opens the frame
            load_rsp   = out_free;
            pair_start = out_free;
         end
         ST_F_READ: ram_re = 1'b1;
         ST_F_SEG: begin
            load_rsp  = out_free;
            load_byte = seg_valid_ff ? ram_rdata : BLANK_CODE;
         end
         ST_F_ZERO: begin
            load_rsp  = out_free;
            load_last = (pair_ff == DIGIT_AW'(NUM_DIGITS - 1));
            pair_step = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clear_all) begin
            valid_ff <= '0;
         end else if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (latch_item) begin
         cmd_ff  <= req_payload.cmd;
         left_ff <= req_payload.left_justify;
      end
      if (measure) begin
         nd_ff  <= nd_calc;
         len_ff <= len_calc;
         ovf_ff <= (cmd_ff == CMD_PRINT_ALL) ? (len_calc > 4'(NUM_DIGITS)) :
                                               (len_calc > 4'(HALF_DIGITS));
         pos_ff <= '0;
      end else if (pos_step) begin
         pos_ff <= pos_ff + 1'b1;
      end
      if (pair_start) begin
         pair_ff <= '0;
      end else if (pair_step) begin
         pair_ff <= pair_ff + 1'b1;
      end
      if (ram_re) begin
         seg_valid_ff <= valid_ff[ram_raddr];
      end
      if (load_rsp) begin
         rsp_payload_ff.frame_byte <= load_byte;
         rsp_payload_ff.last       <= load_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the buffer is never written while a frame is being read out
   a_no_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F_READ || state_ff == ST_F_SEG || state_ff == ST_F_ZERO)
      |-> !ram_we)
      else $error("buffer write during frame readout");

   // the converter only finishes while a print waits for it
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      bcd_res.done |-> state_ff == ST_CONV)
      else $error("converter done outside conversion");

   // closing byte of a frame is a zero pad byte
   a_last_is_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |-> rsp_payload.frame_byte == BLANK_CODE)
      else $error("last frame byte is not a pad byte");

   // loading the closing byte returns the block to idle
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      load_rsp && load_last |=> state_ff == ST_IDLE)
      else $error("frame did not end after its last byte");

endmodule
`default_nettype wire

// ===== hw/rtl/ssnf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ssnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ssnf_bcd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssnf_bcd
// iterative binary to decimal converter, shift-add-3, one bit per cycle
// ----------------------------------------------------------------------------
module ssnf_bcd
   import ssnf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] value,
   output      bcd_status_type     status
);

   logic [MAG_BITS-1:0]             shift_ff, shift_in;
   logic [BCD_DIGITS-1:0][3:0]      bcd_ff, bcd_in;
   logic [STEP_W-1:0]               count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            neg_ff, neg_in;
   logic [BCD_DIGITS-1:0][3:0]      adj;
   logic [MAG_BITS-1:0]             mag;

   // two's complement magnitude; the most negative value lands on 2^31
   assign mag = value[31] ? MAG_BITS'(-value) : MAG_BITS'(value);

   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         adj[d] = (bcd_ff[d] >= 4'd5) ? bcd_ff[d] + 4'd3 : bcd_ff[d];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = mag;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
         neg_in   = value[31];
      end else if (busy_ff) begin
         bcd_in   = {adj[BCD_DIGITS-1:0]} << 1 | (4*BCD_DIGITS)'(shift_ff[MAG_BITS-1]);
         shift_in = shift_ff << 1;
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_W'(MAG_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      neg_ff   <= neg_in;
   end

   assign status = {done_ff, neg_ff, bcd_ff};

endmodule
`default_nettype wire
